/* sv/tsrc_pkg.sv */
// Shared constants and types for the timestamp rate converter.
`default_nettype none
package tsrc_pkg;

	localparam int RATIO_WIDTH = 32;
	localparam int STAMP_W     = 64;
	localparam int PROD_W      = 2 * STAMP_W;
	localparam int HALF_W      = STAMP_W / 2;
	localparam int DIV_STEPS   = PROD_W;
	localparam int ADDR_W      = 6;
	localparam int REG_IDX_W   = 3;

	// register indexes, byte address is 8 * index
	typedef enum logic [REG_IDX_W-1:0] {
		REG_DST_NUMER  = 3'd0,
		REG_DST_DENOM  = 3'd1,
		REG_DST_OFFSET = 3'd2,
		REG_SRC_NUMER  = 3'd3,
		REG_SRC_DENOM  = 3'd4,
		REG_SRC_OFFSET = 3'd5
	} reg_idx_t;

	// sideband that travels with each transaction down the pipe
	typedef struct packed {
		logic vld;
		logic neg;
		logic dz;
	} side_t;

endpackage
`default_nettype wire

/* sv/timestamp_rate_converter.sv */
// Pipeline from input transaction to result: 3 front stages, 128 divider cells,
// 1 output register. Throughput: one transaction per cycle when not stalled; the 128-cell
// restoring divider chain and the split 64x64 multiplier are fully pipelined.
// Input stalls only when the result register and the last divider cell are both full
// and the output is not taken. arst_n clears all valid bits and resets the
// registers to ratio 1/1 and zero offsets; no clearing pass.
`default_nettype none
module timestamp_rate_converter (
	input  wire                             clk,
	input  wire                             arst_n,
	// slave stream
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire [63:0]                      s_axis_tdata,  // [63:0] stamp_in
	// master stream
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [63:0]                     m_axis_tdata,  // [63:0] stamp_out
	output logic [0:0]                      m_axis_tuser,  // [0] overflow
	// configuration
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire [tsrc_pkg::ADDR_W-1:0]      paddr,
	input  wire [63:0]                      pwdata,
	output logic [63:0]                     prdata,
	output logic                            pready
);
	import tsrc_pkg::*;

	// configuration registers
	logic [RATIO_WIDTH-1:0] dst_numer_q, dst_denom_q, src_numer_q, src_denom_q;
	logic [STAMP_W-1:0]     dst_offset_q, src_offset_q;
	reg_idx_t               widx;
	logic                   wr;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
	assign wr     = psel && penable && pwrite;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_numer_q  <= RATIO_WIDTH'(1);
			dst_denom_q  <= RATIO_WIDTH'(1);
			src_numer_q  <= RATIO_WIDTH'(1);
			src_denom_q  <= RATIO_WIDTH'(1);
			dst_offset_q <= '0;
			src_offset_q <= '0;
		end else if (wr) begin
			case (widx)
				REG_DST_NUMER:  dst_numer_q  <= pwdata[RATIO_WIDTH-1:0];
				REG_DST_DENOM:  dst_denom_q  <= pwdata[RATIO_WIDTH-1:0];
				REG_DST_OFFSET: dst_offset_q <= pwdata;
				REG_SRC_NUMER:  src_numer_q  <= pwdata[RATIO_WIDTH-1:0];
				REG_SRC_DENOM:  src_denom_q  <= pwdata[RATIO_WIDTH-1:0];
				REG_SRC_OFFSET: src_offset_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (widx)
			REG_DST_NUMER:  prdata = 64'(dst_numer_q);
			REG_DST_DENOM:  prdata = 64'(dst_denom_q);
			REG_DST_OFFSET: prdata = dst_offset_q;
			REG_SRC_NUMER:  prdata = 64'(src_numer_q);
			REG_SRC_DENOM:  prdata = 64'(src_denom_q);
			REG_SRC_OFFSET: prdata = src_offset_q;
			default:        prdata = '0;
		endcase
	end

	// pipeline advance: output register loads only when free or taken
	logic  en;
	logic  out_en;
	side_t side_c [0:DIV_STEPS];
	logic  out_vld_q;

	assign out_en        = m_axis_tready || !out_vld_q;
	assign en            = out_en || !side_c[DIV_STEPS].vld;
	assign s_axis_tready = en;

	// stage 1: remove source offset, form ratio products
	logic                      neg_c;
	logic [STAMP_W-1:0]        mag_c;
	logic [2*RATIO_WIDTH-1:0]  n_c, d_c;
	side_t                     side_s1;
	logic [STAMP_W-1:0]        mag_s1, n_s1, d_s1;

	always_comb begin
		neg_c = $signed(s_axis_tdata) < $signed(src_offset_q);
		mag_c = neg_c ? (src_offset_q - s_axis_tdata) : (s_axis_tdata - src_offset_q);
		n_c   = dst_numer_q * src_denom_q;
		d_c   = dst_denom_q * src_numer_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1.vld <= s_axis_tvalid;
			side_s1.neg <= neg_c;
			side_s1.dz  <= (d_c == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			n_s1   <= STAMP_W'(n_c);
			d_s1   <= STAMP_W'(d_c);
		end
	end

	// stage 2: four 32x32 partial products
	side_t              side_s2;
	logic [STAMP_W-1:0] p00_s2, p01_s2, p10_s2, p11_s2, d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (en) begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2 <= mag_s1[HALF_W-1:0]       * n_s1[HALF_W-1:0];
			p01_s2 <= mag_s1[HALF_W-1:0]       * n_s1[STAMP_W-1:HALF_W];
			p10_s2 <= mag_s1[STAMP_W-1:HALF_W] * n_s1[HALF_W-1:0];
			p11_s2 <= mag_s1[STAMP_W-1:HALF_W] * n_s1[STAMP_W-1:HALF_W];
			d_s2   <= d_s1;
		end
	end

	// stage 3: sum into the full product
	side_t              side_s3;
	logic [PROD_W-1:0]  prod_s3;
	logic [STAMP_W-1:0] d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3 <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(p00_s2) + (PROD_W'(p01_s2) << HALF_W)
				+ (PROD_W'(p10_s2) << HALF_W) + (PROD_W'(p11_s2) << STAMP_W);
			d_s3    <= d_s2;
		end
	end

	// divider chain
	logic [STAMP_W-1:0] rem_c [0:DIV_STEPS];
	logic [PROD_W-1:0]  nq_c  [0:DIV_STEPS];
	logic [STAMP_W-1:0] dv_c  [0:DIV_STEPS];

	assign side_c[0] = side_s3;
	assign rem_c[0]  = '0;
	assign nq_c[0]   = prod_s3;
	assign dv_c[0]   = d_s3;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		tsrc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (side_c[i]),
			.rem_i  (rem_c[i]),
			.nq_i   (nq_c[i]),
			.d_i    (dv_c[i]),
			.side_o (side_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.nq_o   (nq_c[i+1]),
			.d_o    (dv_c[i+1])
		);
	end

	// final: add destination offset, detect overflow
	side_t              side_l;
	logic [STAMP_W-1:0] qhi, qlo, ob, res_c;
	logic [STAMP_W:0]   sum_c;
	logic               ovf_c;

	always_comb begin
		side_l = side_c[DIV_STEPS];
		qhi    = nq_c[DIV_STEPS][PROD_W-1:STAMP_W];
		qlo    = nq_c[DIV_STEPS][STAMP_W-1:0];
		ob     = dst_offset_q ^ {1'b1, {(STAMP_W-1){1'b0}}};
		sum_c  = {1'b0, qlo} + {1'b0, ob};
		if (side_l.dz) begin
			res_c = '0;
			ovf_c = 1'b1;
		end else if (side_l.neg) begin
			res_c = dst_offset_q - qlo;
			ovf_c = (qhi != '0) || (ob < qlo);
		end else begin
			res_c = dst_offset_q + qlo;
			ovf_c = (qhi != '0) || sum_c[STAMP_W];
		end
	end

	// output register: hold while a result waits
	logic [STAMP_W-1:0] res_q;
	logic               ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_en) begin
			out_vld_q <= side_l.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			res_q <= res_c;
			ovf_q <= ovf_c;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = res_q;
	assign m_axis_tuser[0] = ovf_q;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> out_vld_q && side_c[DIV_STEPS].vld)
		else $error("input stalled with room in the pipe");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> side_s1.vld)
		else $error("accepted transaction lost at stage 1");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && side_l.vld |=> out_vld_q)
		else $error("last cell result not loaded into output");
	a_dz_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		en && side_l.vld && side_l.dz |=> ovf_q && res_q == '0)
		else $error("zero divisor result wrong");

endmodule
`default_nettype wire

/* sv/tsrc_div_cell.sv */
// One restoring division step: shift in a dividend bit, subtract when it fits.
`default_nettype none
module tsrc_div_cell (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             en,
	input  wire tsrc_pkg::side_t            side_i,
	input  wire [tsrc_pkg::STAMP_W-1:0]     rem_i,
	input  wire [tsrc_pkg::PROD_W-1:0]      nq_i,
	input  wire [tsrc_pkg::STAMP_W-1:0]     d_i,
	output tsrc_pkg::side_t                 side_o,
	output logic [tsrc_pkg::STAMP_W-1:0]    rem_o,
	output logic [tsrc_pkg::PROD_W-1:0]     nq_o,
	output logic [tsrc_pkg::STAMP_W-1:0]    d_o
);
	import tsrc_pkg::*;

	logic [STAMP_W-1:0] sh;
	logic               take;
	logic [STAMP_W-1:0] rem_n;

	// shift remainder, compare against divisor (carry means it surely fits)
	always_comb begin
		sh    = {rem_i[STAMP_W-2:0], nq_i[PROD_W-1]};
		take  = rem_i[STAMP_W-1] || (sh >= d_i);
		rem_n = take ? (sh - d_i) : sh;
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= rem_n;
			nq_o  <= {nq_i[PROD_W-2:0], take};
			d_o   <= d_i;
		end
	end

endmodule
`default_nettype wire

/* test/timestamp_rate_converter_tb.sv */
// Self-checking testbench for the timestamp rate converter.
`timescale 1ns / 1ps
module timestamp_rate_converter_tb;
	import tsrc_pkg::*;

	localparam int LATENCY = 132;

	// expected results of the rate conversion, oldest first
	class stamp_scoreboard;
		logic [63:0] dst_numer, dst_denom, dst_offset;
		logic [63:0] src_numer, src_denom, src_offset;
		logic [63:0] exp_stamp[$];
		logic        exp_ovf[$];
		int          errors;

		function new();
			dst_numer = 1; dst_denom = 1; dst_offset = 0;
			src_numer = 1; src_denom = 1; src_offset = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] val);
			logic [63:0] r;
			r = {32'd0, val[31:0]} & ((64'd1 << RATIO_WIDTH) - 64'd1);
			case (idx)
				REG_DST_NUMER:  dst_numer  = r;
				REG_DST_DENOM:  dst_denom  = r;
				REG_DST_OFFSET: dst_offset = val;
				REG_SRC_NUMER:  src_numer  = r;
				REG_SRC_DENOM:  src_denom  = r;
				REG_SRC_OFFSET: src_offset = val;
				default: ;
			endcase
		endfunction

		// scale one stamp with exact signed arithmetic
		function void note_stamp(logic [63:0] stamp);
			logic signed [129:0] diff, scaled, total;
			logic [127:0]        num, den, quo;
			logic [127:0]        mag;
			den = dst_denom * src_numer;
			if (den == 0) begin
				exp_stamp.push_back(64'd0);
				exp_ovf.push_back(1'b1);
				return;
			end
			num = dst_numer * src_denom;
			diff = $signed(stamp) - $signed(src_offset);
			mag = diff < 0 ? -diff : diff;
			quo = (mag * num) / den;
			scaled = $signed({2'b00, quo});
			if (diff < 0)
				scaled = -scaled;
			total = scaled + $signed(dst_offset);
			exp_stamp.push_back(total[63:0]);
			exp_ovf.push_back(total > 130'sh7FFFFFFFFFFFFFFF ||
				total < -130'sh8000000000000000);
		endfunction

		function void check_result(logic [63:0] stamp, logic ovf);
			if (exp_stamp.size() == 0) begin
				$error("unexpected result stamp_out=%h", stamp);
				errors++;
				return;
			end
			if (stamp !== exp_stamp[0]) begin
				$error("stamp_out expected %h actual %h", exp_stamp[0], stamp);
				errors++;
			end
			if (ovf !== exp_ovf[0]) begin
				$error("overflow expected %b actual %b", exp_ovf[0], ovf);
				errors++;
			end
			void'(exp_stamp.pop_front());
			void'(exp_ovf.pop_front());
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;

	stamp_scoreboard sb = new();
	bit  long_hold;
	int  phase;

	timestamp_rate_converter u_dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// write one register through the setup and access cycles
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(8 * idx); pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// send one stamp, waiting on the handshake
	task automatic send_stamp(logic [63:0] stamp);
		s_axis_tvalid <= 1;
		s_axis_tdata  <= stamp;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_stamp(stamp);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.exp_stamp.size() != 0) @(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_stamp();
		case ($urandom_range(0, 5))
			0: return 64'h8000000000000000 + $urandom_range(0, 3);
			1: return 64'h7FFFFFFFFFFFFFFF - $urandom_range(0, 3);
			2: return 64'($signed($urandom_range(0, 2000)) - 1000);
			default: return rand64();
		endcase
	endfunction

	function automatic logic [63:0] rand_ratio();
		case ($urandom_range(0, 4))
			0: return 64'd1;
			1: return 64'hFFFFFFFF;
			2: return 64'($urandom_range(1, 1000));
			default: return {32'd0, $urandom()};
		endcase
	endfunction

	// sender bursts of random length with random gaps
	task automatic random_burst(int count);
		int left, gap;
		left = count;
		while (left > 0) begin
			for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--, left--)
				send_stamp(rand_stamp());
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// receiver: stall pattern plus one long hold-off
	initial begin
		int cnt;
		m_axis_tready = 0;
		cnt = 0;
		forever begin
			@(negedge clk);
			cnt++;
			if (long_hold)
				m_axis_tready <= 0;
			else if (phase % 2 == 0)
				m_axis_tready <= 1;
			else
				m_axis_tready <= (cnt % 7 < 4) || ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int hold;
		long_hold = 0;
		wait (phase == 2);
		@(negedge clk);
		long_hold = 1;
		for (hold = 0; hold < 400; hold++) @(negedge clk);
		long_hold = 0;
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);

	initial begin
		logic [63:0] edge_stamps[$];
		reg_idx_t idx;
		phase = 0;
		arst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset ratio, extremes of the stamp
		edge_stamps = '{64'h0, 64'h1, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000000,
			64'h7FFFFFFFFFFFFFFF, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555};
		foreach (edge_stamps[i]) send_stamp(edge_stamps[i]);
		drain();
		// large scale up with offsets: overflow above the top of the range
		write_reg(REG_DST_NUMER, 64'hFFFFFFFF);
		write_reg(REG_SRC_DENOM, 64'hFFFFFFFF);
		write_reg(REG_SRC_OFFSET, 64'h8000000000000000);
		write_reg(REG_DST_OFFSET, 64'h7FFFFFFFFFFFFFFF);
		foreach (edge_stamps[i]) send_stamp(edge_stamps[i]);
		drain();
		// zero numerator, then zero denominator, then truncation with negative values
		write_reg(REG_DST_NUMER, 64'hFFFFFFFF00000000);
		send_stamp(64'h123456789); send_stamp(64'hFFFFFFFFFFFFFF00);
		drain();
		write_reg(REG_DST_NUMER, 64'd3);
		write_reg(REG_SRC_NUMER, 64'd0);
		send_stamp(64'd77); send_stamp(64'h8000000000000000);
		drain();
		write_reg(REG_SRC_NUMER, 64'd7);
		write_reg(REG_DST_DENOM, 64'd1);
		write_reg(REG_SRC_DENOM, 64'd1);
		write_reg(REG_SRC_OFFSET, 64'd0);
		write_reg(REG_DST_OFFSET, 64'd0);
		send_stamp(64'd10); send_stamp(-64'sd10); send_stamp(-64'sd6); send_stamp(64'd6);
		drain();

		// random phases; phase 2 stalls the receiver for a long stretch
		for (int p = 1; p <= 8; p++) begin
			phase = p;
			for (int r = 0; r < 6; r++) begin
				idx = reg_idx_t'(r);
				if (idx == REG_DST_OFFSET || idx == REG_SRC_OFFSET)
					write_reg(idx, $urandom_range(0, 2) == 0 ? 64'd0 : rand64());
				else
					write_reg(idx, $urandom_range(0, 15) == 0 ? 64'd0 : rand_ratio());
			end
			random_burst(p == 2 ? 300 : 70);
			drain();
		end

		if (sb.errors == 0 && sb.exp_stamp.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* files.f */
sv/tsrc_pkg.sv
sv/tsrc_div_cell.sv
sv/timestamp_rate_converter.sv
test/timestamp_rate_converter_tb.sv
